[sv/fbc32_pkg.sv]
package fbc32_pkg;

  localparam int WORD_W = 16;
  localparam logic [WORD_W-1:0] KEY_CONST = 16'h000C;

  // Control for one storage cell: a parallel load wins over a shift.
  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctl_t;

  typedef logic [3:0] nibble_t;
  typedef nibble_t sbox_t [16];

  localparam sbox_t SBOX = '{
    4'hE, 4'hB, 4'h4, 4'h6, 4'hA, 4'hD, 4'h7, 4'h0,
    4'h3, 4'h8, 4'hF, 4'hC, 4'h5, 4'h9, 4'h1, 4'h2
  };

  function automatic logic [WORD_W-1:0] perm16(input logic [WORD_W-1:0] v);
    logic [WORD_W-1:0] r;
    r = ((v & 16'hC00C) >> 1)
      | ((v & 16'h2000) >> 6)
      | ((v & 16'h1000) >> 8)
      | ((v & 16'h0C00) >> 5)
      | ((v & 16'h0200) << 6)
      | ((v & 16'h0100) << 4)
      | ((v & 16'h00C0) << 3)
      | ((v & 16'h0020) >> 2)
      | ((v & 16'h0010) >> 4)
      | ((v & 16'h0002) << 10)
      | ((v & 16'h0001) << 8);
    return r;
  endfunction

  function automatic logic [WORD_W-1:0] subst16(input logic [WORD_W-1:0] v);
    logic [WORD_W-1:0] r;
    for (int i = 0; i < 4; i++) begin
      r[i*4 +: 4] = SBOX[v[i*4 +: 4]];
    end
    return r;
  endfunction

endpackage

[sv/feistel_block_cipher_32_unit.sv]
// Channel   Direction  Payload
// in_       slave      tdata[31:0] = data_in (left half in bits 31..16)
// out_      master     tdata[31:0] = data_out; tuser[0] = bad_setting
// cfg_      slave      index 0 cipher_key, 1 round_count, 2 cipher_mode
//
// With n = min(round_count, MAX_ROUNDS), encryption and direct-key decryption run n
// rounds per block; decryption from the master key first derives the key, which
// runs on the same key chain before the rounds start.
// The single round datapath runs one Feistel round a cycle.
// Reset is synchronous, active low, and resets all registers but the cell chains.
// A finished result sits in the output register while the next block is taken;
// a block only stalls in its final state if the previous result is still waiting.
module feistel_block_cipher_32_unit #(
  parameter int MAX_ROUNDS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,     // [31:0] data_in
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,    // [31:0] data_out
  output logic        out_tuser,    // [0] bad_setting
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int W  = fbc32_pkg::WORD_W;
  localparam int CW = $clog2(MAX_ROUNDS + 1);
  localparam int EW = (CW > 6) ? CW : 6;

  localparam logic [1:0] REG_KEY    = 2'd0;
  localparam logic [1:0] REG_ROUNDS = 2'd1;
  localparam logic [1:0] REG_MODE   = 2'd2;

  localparam logic [1:0] MODE_ENC        = 2'd0;
  localparam logic [1:0] MODE_DEC_DERIVE = 2'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DERIVE,
    ST_RUN,
    ST_DONE
  } state_t;

  // Configuration registers.
  logic [63:0] key_r;
  logic [5:0]  rounds_r;
  logic [1:0]  mode_r;

  // Sequencer state and output register.
  state_t        state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic          dec_r, dec_nxt;
  logic          bad_r, bad_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [31:0]   out_data_r, out_data_nxt;
  logic          out_bad_r, out_bad_nxt;

  // Cell chains: four key window words and the two cipher halves.
  fbc32_pkg::cell_ctl_t key_ctl, half_ctl;
  logic [W-1:0] key_word   [4];
  logic [W-1:0] key_load   [4];
  logic [W-1:0] key_shift  [4];
  logic [W-1:0] left_word, right_word;
  logic [W-1:0] left_load, right_load;

  logic          in_xfer, out_xfer;
  logic [EW-1:0] rounds_ext;
  logic [CW-1:0] n_sat;
  logic          shift_dec;
  logic [W-1:0]  key_fb;
  logic [W-1:0]  round_out;
  logic          out_free;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r    <= '0;
      rounds_r <= 6'd16;
      mode_r   <= MODE_ENC;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_KEY:    key_r    <= cfg_data;
        REG_ROUNDS: rounds_r <= cfg_data[5:0];
        REG_MODE:   mode_r   <= cfg_data[1:0];
        default:    ;
      endcase
    end
  end

  assign in_tready = (state_r == ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign out_xfer  = out_valid_r && out_tready;
  assign out_free  = !out_valid_r || out_tready;

  // Round count saturates at the unit's round limit.
  assign rounds_ext = EW'(rounds_r);
  assign n_sat = (rounds_ext > EW'(MAX_ROUNDS)) ? CW'(MAX_ROUNDS) : CW'(rounds_ext);

  // Key derivation always uses the encryption recurrence; rounds follow the mode.
  assign shift_dec = (state_r == ST_RUN) && dec_r;
  assign key_fb = key_word[0] ^ (shift_dec ? key_word[1] : key_word[3])
                ^ fbc32_pkg::perm16(key_word[2]) ^ fbc32_pkg::KEY_CONST;

  assign round_out = fbc32_pkg::perm16(fbc32_pkg::subst16(left_word))
                   ^ right_word ^ key_word[0];

  always_comb begin
    key_ctl    = '{load: 1'b0, shift: 1'b0};
    half_ctl   = '{load: 1'b0, shift: 1'b0};
    left_load  = in_tdata[31:16];
    right_load = in_tdata[15:0];
    for (int i = 0; i < 4; i++) begin
      key_load[i] = key_r[(3-i)*W +: W];
    end

    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    n_nxt         = n_r;
    dec_nxt       = dec_r;
    bad_nxt       = bad_r;
    out_valid_nxt = out_xfer ? 1'b0 : out_valid_r;
    out_data_nxt  = out_data_r;
    out_bad_nxt   = out_bad_r;

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          n_nxt   = n_sat;
          dec_nxt = (mode_r != MODE_ENC);
          bad_nxt = 1'b0;
          half_ctl.load = 1'b1;
          key_ctl.load  = 1'b1;
          if (mode_r != MODE_ENC) begin
            // Decryption swaps the halves on the way in.
            left_load  = in_tdata[15:0];
            right_load = in_tdata[31:16];
          end
          if (mode_r == MODE_DEC_DERIVE) begin
            if (n_sat < CW'(4)) begin
              bad_nxt   = 1'b1;
              state_nxt = ST_DONE;
            end else begin
              // Encryption layout; the schedule is run forward first.
              cnt_nxt   = CW'(4);
              state_nxt = ST_DERIVE;
            end
          end else begin
            if (mode_r != MODE_ENC) begin
              for (int i = 0; i < 4; i++) begin
                key_load[i] = key_r[i*W +: W];
              end
            end
            cnt_nxt   = '0;
            state_nxt = ST_RUN;
          end
        end
      end
      ST_DERIVE: begin
        if (cnt_r == n_r) begin
          // The newest four words, reversed, become the decryption window.
          key_ctl.load = 1'b1;
          for (int i = 0; i < 4; i++) begin
            key_load[i] = key_word[3-i];
          end
          cnt_nxt   = '0;
          state_nxt = ST_RUN;
        end else begin
          key_ctl.shift = 1'b1;
          cnt_nxt       = cnt_r + CW'(1);
        end
      end
      ST_RUN: begin
        if (cnt_r == n_r) begin
          state_nxt = ST_DONE;
        end else begin
          key_ctl.shift  = 1'b1;
          half_ctl.shift = 1'b1;
          cnt_nxt        = cnt_r + CW'(1);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_bad_nxt   = bad_r;
          if (bad_r) begin
            out_data_nxt = '0;
          end else if (dec_r) begin
            out_data_nxt = {right_word, left_word};
          end else begin
            out_data_nxt = {left_word, right_word};
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      n_r         <= '0;
      dec_r       <= 1'b0;
      bad_r       <= 1'b0;
      out_valid_r <= 1'b0;
      out_data_r  <= '0;
      out_bad_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      n_r         <= n_nxt;
      dec_r       <= dec_nxt;
      bad_r       <= bad_nxt;
      out_valid_r <= out_valid_nxt;
      out_data_r  <= out_data_nxt;
      out_bad_r   <= out_bad_nxt;
    end
  end

  // Key window chain: each word moves one cell toward the head every shift.
  for (genvar g = 0; g < 4; g++) begin : g_key
    if (g == 3) begin : g_tail
      assign key_shift[g] = key_fb;
    end else begin : g_body
      assign key_shift[g] = key_word[g+1];
    end
    fbc32_cell u_key_cell (
      .clk        (clk),
      .ctl        (key_ctl),
      .load_word  (key_load[g]),
      .shift_word (key_shift[g]),
      .word       (key_word[g])
    );
  end

  // Half chain: the new left half enters, the old left half moves to the right.
  fbc32_cell u_left_cell (
    .clk        (clk),
    .ctl        (half_ctl),
    .load_word  (left_load),
    .shift_word (round_out),
    .word       (left_word)
  );

  fbc32_cell u_right_cell (
    .clk        (clk),
    .ctl        (half_ctl),
    .load_word  (right_load),
    .shift_word (left_word),
    .word       (right_word)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_bad_r;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN || state_r == ST_DERIVE) |-> (cnt_r <= n_r))
    else $error("round counter ran past the round count");

  a_derive_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DERIVE) |-> (dec_r && (n_r >= CW'(4))))
    else $error("key derivation entered without a valid decrypt setting");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata == 32'd0))
    else $error("flagged result carries nonzero data");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r != ST_IDLE))
    else $error("sequencer stayed idle after a block transfer");
`endif

endmodule

[sv/fbc32_cell.sv]
// One 16-bit cell of a shift chain: takes a parallel value or its neighbor's word.
module fbc32_cell (
  input  logic                             clk,
  input  fbc32_pkg::cell_ctl_t             ctl,
  input  logic [fbc32_pkg::WORD_W-1:0]     load_word,
  input  logic [fbc32_pkg::WORD_W-1:0]     shift_word,
  output logic [fbc32_pkg::WORD_W-1:0]     word
);

  logic [fbc32_pkg::WORD_W-1:0] word_r;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      word_r <= load_word;
    end else if (ctl.shift) begin
      word_r <= shift_word;
    end
  end

  assign word = word_r;

endmodule

[sim/fbc32_cipher_check.sv]
`timescale 1ns / 1ps

package fbc32_tb_codes_pkg;

  localparam int ROUND_LIMIT = 32;
  localparam logic [15:0] KEY_TWEAK = 16'h000C;

  typedef enum logic [1:0] {
    MODE_ENCRYPT         = 2'd0,
    MODE_DECRYPT_DERIVED = 2'd1,
    MODE_DECRYPT_DIRECT  = 2'd2,
    MODE_DECRYPT_SPARE   = 2'd3
  } cipher_mode_t;

  typedef enum logic [1:0] {
    REG_CIPHER_KEY  = 2'd0,
    REG_ROUND_COUNT = 2'd1,
    REG_CIPHER_MODE = 2'd2,
    REG_UNUSED      = 2'd3
  } reg_index_t;

endpackage

module fbc32_cipher_check (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic        out_tuser,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output int          mismatches,
  output int          outstanding
);

  typedef struct packed {
    logic [31:0] block;
    logic        bad_setting;
  } cipher_out_t;

  // Nibble substitution table, entry i in bits 4i+3..4i.
  localparam logic [63:0] NIBBLE_SUBST = 64'h2195_CF83_07DA_64BE;

  logic [63:0]                      key_q;
  logic [5:0]                       rounds_q;
  fbc32_tb_codes_pkg::cipher_mode_t mode_q;
  int                               fail_count = 0;
  cipher_out_t                      expected_blocks [$];

  // Appends one predicted result at the tail of the queue.
  function automatic void enqueue_expected(input cipher_out_t item);
    expected_blocks = {expected_blocks, item};
  endfunction

  function automatic logic [15:0] bit_shuffle(input logic [15:0] x);
    return {x[9], x[15], x[14], x[8], x[1], x[7], x[6], x[0],
            x[13], x[11], x[10], x[12], x[5], x[3], x[2], x[4]};
  endfunction

  function automatic logic [15:0] substitute(input logic [15:0] x);
    logic [15:0] r;
    for (int k = 0; k < 4; k++) begin
      r[4*k +: 4] = NIBBLE_SUBST[x[4*k +: 4]*4 +: 4];
    end
    return r;
  endfunction

  function automatic logic [15:0] next_key_word(input logic [3:0][15:0] w,
                                                input logic decrypt);
    return w[0] ^ (decrypt ? w[1] : w[3]) ^ bit_shuffle(w[2])
           ^ fbc32_tb_codes_pkg::KEY_TWEAK;
  endfunction

  function automatic cipher_out_t cipher_result(
    input logic [31:0]                      blk,
    input logic [63:0]                      key,
    input logic [5:0]                       rounds,
    input fbc32_tb_codes_pkg::cipher_mode_t mode
  );
    logic [3:0][15:0] win;
    logic [15:0]      lh, rh, nl;
    logic [63:0]      round_key;
    logic             decrypt;
    int               n;
    cipher_out_t      res;
    n = (rounds > fbc32_tb_codes_pkg::ROUND_LIMIT) ? fbc32_tb_codes_pkg::ROUND_LIMIT
                                                   : int'(rounds);
    decrypt = (mode != fbc32_tb_codes_pkg::MODE_ENCRYPT);
    round_key = key;
    res = '0;
    if (mode == fbc32_tb_codes_pkg::MODE_DECRYPT_DERIVED) begin
      if (n < 4) begin
        res.bad_setting = 1'b1;
        return res;
      end
      // Run the encryption schedule forward; its last four words, newest
      // first from the low end, become the decryption key.
      win = {key[15:0], key[31:16], key[47:32], key[63:48]};
      for (int i = 4; i < n; i++) begin
        win = {next_key_word(win, 1'b0), win[3:1]};
      end
      round_key = {win[0], win[1], win[2], win[3]};
    end
    if (decrypt) begin
      {rh, lh} = blk;
      win = round_key;
    end else begin
      {lh, rh} = blk;
      win = {round_key[15:0], round_key[31:16], round_key[47:32], round_key[63:48]};
    end
    for (int i = 0; i < n; i++) begin
      nl = bit_shuffle(substitute(lh)) ^ rh ^ win[0];
      rh = lh;
      lh = nl;
      win = {next_key_word(win, decrypt), win[3:1]};
    end
    res.block = decrypt ? {rh, lh} : {lh, rh};
    return res;
  endfunction

  always @(posedge clk) begin : watch
    cipher_out_t want;
    if (!rst_n) begin
      key_q = '0;
      rounds_q = 6'd16;
      mode_q = fbc32_tb_codes_pkg::MODE_ENCRYPT;
      expected_blocks.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_blocks.size() == 0) begin
          fail_count++;
          $error("result transfer with no block pending: data_out %h, bad_setting %b",
                 out_tdata, out_tuser);
        end else begin
          want = expected_blocks.pop_front();
          if (out_tdata !== want.block) begin
            fail_count++;
            $error("data_out: expected %h, got %h", want.block, out_tdata);
          end
          if (out_tuser !== want.bad_setting) begin
            fail_count++;
            $error("bad_setting: expected %b, got %b", want.bad_setting, out_tuser);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          fbc32_tb_codes_pkg::REG_CIPHER_KEY:  key_q = cfg_data;
          fbc32_tb_codes_pkg::REG_ROUND_COUNT: rounds_q = cfg_data[5:0];
          fbc32_tb_codes_pkg::REG_CIPHER_MODE:
            mode_q = fbc32_tb_codes_pkg::cipher_mode_t'(cfg_data[1:0]);
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        enqueue_expected(cipher_result(in_tdata, key_q, rounds_q, mode_q));
      end
    end
    mismatches <= fail_count;
    outstanding <= expected_blocks.size();
  end

endmodule

[sim/feistel_block_cipher_32_unit_tb.sv]
`timescale 1ns / 1ps

module feistel_block_cipher_32_unit_tb;

  // Cycles allowed after the last expected result before the verdict. The
  // slowest block is a derived-key decryption at the round limit: the key
  // derivation plus the rounds plus the load and result states.
  localparam int SETTLE_CYCLES = 2 * fbc32_tb_codes_pkg::ROUND_LIMIT + 16;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic [31:0] in_tdata = '0;
  logic        out_tready = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;
  wire         in_tready;
  wire         out_tvalid;
  wire  [31:0] out_tdata;
  wire         out_tuser;
  wire         cfg_ready;

  int mismatches;
  int outstanding;
  // Chance in a hundred that the sender idles or the receiver stalls on a cycle.
  int send_idle_pct = 0;
  int stall_pct = 0;

  feistel_block_cipher_32_unit #(
    .MAX_ROUNDS(fbc32_tb_codes_pkg::ROUND_LIMIT)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // The checker sees every transfer on all three channels, keeps its own copy
  // of the registers and predicts each result at the moment its block is taken.
  fbc32_cipher_check cipher_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // The receiver decides afresh on every cycle whether it takes a result.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Offers one block, after a random idle stretch, and returns at the edge
  // where it is taken. Valid is left high so that a following block goes out
  // back to back; whoever comes next decides whether it drops.
  task automatic send_block(input logic [31:0] blk);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= blk;
    do @(posedge clk); while (!in_tready);
  endtask

  // Stops sending and waits until every predicted result has come out. The
  // first edge lets the checker count a block taken at the current edge.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One register write; valid stays high so writes can follow back to back.
  task automatic write_reg(input fbc32_tb_codes_pkg::reg_index_t idx,
                           input logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Registers change only while the block is idle.
  task automatic set_config(input logic [63:0] key, input logic [63:0] rounds_word,
                            input logic [63:0] mode_word);
    wait_drained();
    write_reg(fbc32_tb_codes_pkg::REG_CIPHER_KEY, key);
    write_reg(fbc32_tb_codes_pkg::REG_ROUND_COUNT, rounds_word);
    write_reg(fbc32_tb_codes_pkg::REG_CIPHER_MODE, mode_word);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    logic [63:0] key;
    logic [63:0] junk;
    logic [5:0]  rounds;
    logic [1:0]  mode;
    logic [31:0] blk;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Values after reset: encryption over sixteen rounds with an all-zero key.
    send_block(32'h0000_0000);
    send_block(32'hFFFF_FFFF);

    // All-ones key at the round limit, with alternating extreme blocks.
    set_config('1, 64'd32, fbc32_tb_codes_pkg::MODE_ENCRYPT);
    send_block(32'h8000_0001);
    send_block(32'h7FFF_FFFE);

    // With no rounds at all the block passes through; in decryption the two
    // half swaps cancel out.
    set_config(64'h0123_4567_89AB_CDEF, 64'd0, fbc32_tb_codes_pkg::MODE_ENCRYPT);
    send_block(32'hA5A5_5A5A);
    set_config(64'h0123_4567_89AB_CDEF, 64'd0, fbc32_tb_codes_pkg::MODE_DECRYPT_DIRECT);
    send_block(32'h1234_5678);

    // Deriving the decryption key needs at least four rounds; below that the
    // result is zero and flagged.
    set_config({$urandom, $urandom}, 64'd3, fbc32_tb_codes_pkg::MODE_DECRYPT_DERIVED);
    send_block(32'hDEAD_BEEF);
    set_config({$urandom, $urandom}, 64'd0, fbc32_tb_codes_pkg::MODE_DECRYPT_DERIVED);
    send_block(32'hFFFF_FFFF);

    // Exactly four rounds: the derived key is the master key with its words
    // reversed, and no schedule step runs during derivation.
    set_config({$urandom, $urandom}, 64'd4, fbc32_tb_codes_pkg::MODE_DECRYPT_DERIVED);
    send_block($urandom);
    send_block($urandom);

    // Round counts above the limit saturate, in both decrypt flavors.
    set_config({$urandom, $urandom}, 64'd63, fbc32_tb_codes_pkg::MODE_DECRYPT_DERIVED);
    send_block($urandom);
    send_block($urandom);
    set_config({$urandom, $urandom}, 64'd33, fbc32_tb_codes_pkg::MODE_DECRYPT_DIRECT);
    send_block($urandom);

    // The spare mode code behaves as decryption with the key as given.
    set_config({$urandom, $urandom}, 64'd1, fbc32_tb_codes_pkg::MODE_DECRYPT_SPARE);
    send_block($urandom);
    send_block($urandom);

    // A write to the unused register index must leave the settings alone.
    set_config(64'hFEDC_BA98_7654_3210, 64'd16, fbc32_tb_codes_pkg::MODE_ENCRYPT);
    send_block(32'h0F0F_F0F0);
    wait_drained();
    write_reg(fbc32_tb_codes_pkg::REG_UNUSED, '1);
    cfg_valid <= 1'b0;
    send_block(32'h0F0F_F0F0);

    // Random part: four idling profiles, each over a dozen random settings.
    // Rounds and mode sometimes carry junk in the upper data bits, which the
    // block has to ignore.
    for (int ph = 0; ph < 4; ph++) begin
      for (int s = 0; s < 12; s++) begin
        case ($urandom_range(9))
          0:       key = '0;
          1:       key = '1;
          default: key = {$urandom, $urandom};
        endcase
        case ($urandom_range(7))
          0:       rounds = 6'd0;
          1:       rounds = 6'($urandom_range(1, 4));
          2:       rounds = 6'($urandom_range(33, 63));
          3:       rounds = 6'd32;
          default: rounds = 6'($urandom_range(5, 31));
        endcase
        mode = 2'($urandom_range(3));
        junk = {$urandom, $urandom};
        set_config(key,
                   $urandom_range(1) ? {junk[63:6], rounds} : {58'd0, rounds},
                   $urandom_range(1) ? {junk[63:2], mode} : {62'd0, mode});
        case (ph)
          0: begin
            send_idle_pct = 0;
            stall_pct <= 0;
          end
          1: begin
            send_idle_pct = 74;
            stall_pct <= 0;
          end
          2: begin
            send_idle_pct = 0;
            stall_pct <= 74;
          end
          default: begin
            send_idle_pct = 37;
            stall_pct <= 37;
          end
        endcase
        for (int k = 0; k < 40; k++) begin
          case ($urandom_range(15))
            0:       blk = 32'h0000_0000;
            1:       blk = 32'hFFFF_FFFF;
            default: blk = $urandom;
          endcase
          send_block(blk);
          // Halfway through each setting the sender holds off until the
          // pipeline has run completely dry.
          if (k == 20) begin
            wait_drained();
          end
        end
      end
    end

    send_idle_pct = 0;
    stall_pct <= 0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("feistel_block_cipher_32_unit_tb OK");
    end else begin
      $display("feistel_block_cipher_32_unit_tb NOT OK");
    end
    $finish;
  end

  // Safety net far beyond the slowest correct run.
  initial begin : watchdog
    #10_000_000;
    $display("feistel_block_cipher_32_unit_tb NOT OK");
    $finish;
  end

endmodule
